[src/bpa_pkg.sv]
package bpa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int WORD_BITS = 32;
  localparam int WORDS     = MAX_PAGES / WORD_BITS;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int WORD_AW   = $clog2(WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int BYTES_W   = 26;
  localparam int NEED_W    = 22;
  localparam int PAD_W     = 16;
  localparam int PSIZE_W   = 17;
  localparam int QDEPTH    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [3:0] SIZE_CODES = 4'd12;
  localparam logic [3:0] BASE_SHIFT = 4'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_NOROOM  = 3'd2;
  localparam logic [2:0] ST_NOFIT   = 3'd3;
  localparam logic [2:0] ST_BADFREE = 3'd4;

  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_EMPTY = 2'd1;
  localparam logic [1:0] K_FREE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_OK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL      = 3'd5;

  typedef struct packed {
    logic [3:0]       page_code;
    logic [3:0]       extra;
    logic [3:0]       guard;
    logic [1:0]       fit;
    logic             allow_empty;
    logic [CNT_W-1:0] pool;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NEED_W-1:0] need;
    logic [PAD_W-1:0]  pad;
    logic [PAGE_W-1:0] start;
  } cmd_t;

  typedef struct packed {
    logic             clearing;
    logic [CNT_W-1:0] free_cnt;
  } back_stat_t;

endpackage

[src/bpa_ram.sv]
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bpa_front.sv]
module bpa_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,
  input  logic              s_tuser,
  input  bpa_pkg::cfg_t     cfg,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output bpa_pkg::cmd_t     push_cmd
);
  import bpa_pkg::*;

  logic [3:0]           shift;
  logic [4:0]           sh_amt;
  logic [PSIZE_W-1:0]   pmask;
  logic [BYTES_W:0]     sum;
  logic [BYTES_W:0]     shifted;
  logic [NEED_W-1:0]    data_pages;
  logic [PSIZE_W-1:0]   rem;
  logic [PSIZE_W-1:0]   pad_full;
  logic [BYTES_W-1:0]   bytes;

  assign bytes = s_tdata[BYTES_W-1:0];
  assign shift = (cfg.page_code >= SIZE_CODES) ? cfg.page_code - SIZE_CODES : cfg.page_code;
  // five bits: the largest page needs a shift of sixteen
  assign sh_amt = 5'(shift) + 5'(BASE_SHIFT);
  assign pmask = (PSIZE_W'(32) << shift) - PSIZE_W'(1);
  assign sum = {1'b0, bytes} + (BYTES_W+1)'(pmask);
  assign shifted = sum >> sh_amt;
  assign data_pages = shifted[NEED_W-1:0];
  assign rem = PSIZE_W'(bytes) & pmask;
  // bytes short of a whole page: (-bytes) mod page size
  assign pad_full = (~rem + PSIZE_W'(1)) & pmask;

  assign s_tready = !q_full && !clearing;
  assign push = s_tvalid && s_tready;

  always_comb begin
    push_cmd.need  = data_pages + NEED_W'(1) + NEED_W'(cfg.extra) + NEED_W'({cfg.guard, 1'b0});
    push_cmd.pad   = pad_full[PAD_W-1:0];
    push_cmd.start = s_tdata[BYTES_W+PAGE_W-1:BYTES_W];
    if (s_tuser) begin
      push_cmd.kind = K_FREE;
    end else if (data_pages == '0 && !cfg.allow_empty) begin
      push_cmd.kind = K_EMPTY;
    end else begin
      push_cmd.kind = K_ALLOC;
    end
  end

endmodule

[src/bpa_cmd_fifo.sv]
module bpa_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpa_pkg::cmd_t push_cmd,
  input  logic          pop,
  output bpa_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);
  import bpa_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t             mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

[src/bpa_back.sv]
module bpa_back (
  input  logic                clk,
  input  logic                rst,
  input  bpa_pkg::cfg_t       cfg,
  input  logic                pool_wr,
  input  logic                q_empty,
  input  bpa_pkg::cmd_t       q_cmd,
  output logic                pop,
  output bpa_pkg::back_stat_t stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,
  output logic [2:0]          m_tuser
);
  import bpa_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_SRD  = 4'd3;
  localparam logic [3:0] S_SBIT = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_MRD  = 4'd7;
  localparam logic [3:0] S_MWR  = 4'd8;
  localparam logic [3:0] S_HRD  = 4'd9;
  localparam logic [3:0] S_HWR  = 4'd10;
  localparam logic [3:0] S_RES  = 4'd11;

  logic [3:0]         state;
  logic [WORD_AW-1:0] clr_addr;
  logic [CNT_W-1:0]   free_cnt;
  cmd_t               cur;
  logic [CNT_W-1:0]   page;
  logic [PAGE_W-1:0]  run_start;
  logic [CNT_W-1:0]   run_len;
  logic [PAGE_W-1:0]  best_start;
  logic [CNT_W-1:0]   best_len;
  logic               found;
  logic [PAGE_W-1:0]  lo;
  logic [PAGE_W-1:0]  hi;
  logic               set_val;
  logic [WORD_AW-1:0] w;
  logic [2:0]         res_status;
  logic [PAGE_W-1:0]  res_start;
  logic [CNT_W-1:0]   res_pages;
  logic [PAD_W-1:0]   res_pad;
  logic [CNT_W-1:0]   res_free;
  logic               res_load;

  // memory ports
  logic                 used_we, used_re, head_we, head_re, len_we, len_re;
  logic [WORD_AW-1:0]   used_waddr, used_raddr, head_waddr, head_raddr;
  logic [WORD_BITS-1:0] used_wdata, used_rd, head_wdata, head_rd;
  logic [PAGE_W-1:0]    len_waddr, len_raddr;
  logic [CNT_W-1:0]     len_wdata, len_rd;

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_used (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .re(used_re), .raddr(used_raddr), .rdata(used_rd));

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_rd));

  bpa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PAGES)) u_len (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .re(len_re), .raddr(len_raddr), .rdata(len_rd));

  // scan step
  logic              pg_free, fit_ok, take, stop_first, end_scan, found_now;
  logic [PAGE_W-1:0] sel_start, sel_hi;
  logic [NEED_W-1:0] need;

  assign need       = cur.need;
  assign pg_free    = (page < cfg.pool) && !used_rd[page[BIT_W-1:0]];
  assign fit_ok     = NEED_W'(run_len) >= need;
  assign take       = fit_ok && (!found
                      || (cfg.fit == FIT_BEST && run_len < best_len)
                      || (cfg.fit == FIT_WORST && run_len > best_len));
  assign stop_first = fit_ok && cfg.fit != FIT_BEST && cfg.fit != FIT_WORST;
  assign end_scan   = !pg_free && (stop_first || page == cfg.pool);
  assign found_now  = found || take;
  assign sel_start  = take ? run_start : best_start;
  assign sel_hi     = sel_start + need[PAGE_W-1:0] - PAGE_W'(1);

  // free check
  logic [CNT_W:0]    f_end, f_end_c, f_sum;
  logic [CNT_W-1:0]  f_new;
  logic [PAGE_W-1:0] f_hi;
  logic              f_ok;

  assign f_ok    = head_rd[cur.start[BIT_W-1:0]] && used_rd[cur.start[BIT_W-1:0]];
  assign f_end   = (CNT_W+1)'(cur.start) + (CNT_W+1)'(len_rd);
  assign f_end_c = (f_end > (CNT_W+1)'(cfg.pool)) ? (CNT_W+1)'(cfg.pool) : f_end;
  assign f_hi    = PAGE_W'(f_end_c - (CNT_W+1)'(1));
  assign f_sum   = (CNT_W+1)'(free_cnt) + (CNT_W+1)'(len_rd);
  assign f_new   = (f_sum > (CNT_W+1)'(cfg.pool)) ? cfg.pool : f_sum[CNT_W-1:0];

  // range mask over the word being patched
  logic [WORD_BITS-1:0] mask;
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = ({w, BIT_W'(b)} >= lo) && ({w, BIT_W'(b)} <= hi);
    end
  end

  always_comb begin
    used_we = 1'b0; used_waddr = w; used_wdata = '0;
    used_re = 1'b0; used_raddr = page[PAGE_W-1:BIT_W];
    head_we = 1'b0; head_waddr = lo[PAGE_W-1:BIT_W]; head_wdata = '0;
    head_re = 1'b0; head_raddr = lo[PAGE_W-1:BIT_W];
    len_we = 1'b0; len_waddr = lo; len_wdata = need[CNT_W-1:0];
    len_re = 1'b0; len_raddr = cur.start;
    case (state)
      S_CLR: begin
        used_we = 1'b1; used_waddr = clr_addr;
        head_we = 1'b1; head_waddr = clr_addr;
      end
      S_SRD: used_re = 1'b1;
      S_FRD: begin
        used_re = 1'b1; used_raddr = cur.start[PAGE_W-1:BIT_W];
        head_re = 1'b1; head_raddr = cur.start[PAGE_W-1:BIT_W];
        len_re  = 1'b1;
      end
      S_MRD: begin
        used_re = 1'b1; used_raddr = w;
      end
      S_MWR: begin
        used_we    = 1'b1;
        used_wdata = set_val ? (used_rd | mask) : (used_rd & ~mask);
      end
      S_HRD: head_re = 1'b1;
      S_HWR: begin
        head_we    = 1'b1;
        head_wdata = head_rd;
        head_wdata[lo[BIT_W-1:0]] = set_val;
        len_we     = set_val;
      end
      default: ;
    endcase
  end

  assign pop           = (state == S_IDLE) && !q_empty;
  assign stat.clearing = (state == S_CLR);
  assign stat.free_cnt = free_cnt;
  // result register loads when it is empty or being drained
  assign res_load      = !pool_wr && (state == S_RES) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pool_wr) begin
        state    <= S_CLR;
        clr_addr <= '0;
      end else begin
        case (state)
          S_CLR: begin
            clr_addr <= clr_addr + WORD_AW'(1);
            if (clr_addr == WORD_AW'(WORDS-1)) begin
              free_cnt <= cfg.pool;
              state    <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (!q_empty) begin
              cur   <= q_cmd;
              state <= S_DISP;
            end
          end
          S_DISP: begin
            res_start <= (cur.kind == K_FREE) ? cur.start : '0;
            res_pages <= '0;
            res_pad   <= '0;
            res_free  <= free_cnt;
            case (cur.kind)
              K_EMPTY: begin
                res_status <= ST_EMPTY;
                state      <= S_RES;
              end
              K_FREE: begin
                if (CNT_W'(cur.start) >= cfg.pool) begin
                  res_status <= ST_BADFREE;
                  state      <= S_RES;
                end else begin
                  state <= S_FRD;
                end
              end
              default: begin
                if (need > NEED_W'(free_cnt)) begin
                  res_status <= ST_NOROOM;
                  state      <= S_RES;
                end else begin
                  page    <= '0;
                  run_len <= '0;
                  found   <= 1'b0;
                  state   <= S_SRD;
                end
              end
            endcase
          end
          S_SRD: state <= S_SBIT;
          S_SBIT: begin
            if (pg_free) begin
              if (run_len == '0) begin
                run_start <= page[PAGE_W-1:0];
              end
              run_len <= run_len + CNT_W'(1);
            end else begin
              run_len <= '0;
              if (take) begin
                found      <= 1'b1;
                best_start <= run_start;
                best_len   <= run_len;
              end
            end
            if (end_scan) begin
              if (found_now) begin
                lo         <= sel_start;
                hi         <= sel_hi;
                w          <= sel_start[PAGE_W-1:BIT_W];
                set_val    <= 1'b1;
                free_cnt   <= free_cnt - need[CNT_W-1:0];
                res_status <= ST_OK;
                res_start  <= sel_start;
                res_pages  <= need[CNT_W-1:0];
                res_pad    <= cur.pad;
                res_free   <= free_cnt - need[CNT_W-1:0];
                state      <= S_MRD;
              end else begin
                res_status <= ST_NOFIT;
                state      <= S_RES;
              end
            end else begin
              page  <= page + CNT_W'(1);
              state <= (page[BIT_W-1:0] == '1) ? S_SRD : S_SBIT;
            end
          end
          S_FRD: state <= S_FCHK;
          S_FCHK: begin
            if (!f_ok) begin
              res_status <= ST_BADFREE;
              state      <= S_RES;
            end else begin
              lo         <= cur.start;
              hi         <= f_hi;
              w          <= cur.start[PAGE_W-1:BIT_W];
              set_val    <= 1'b0;
              free_cnt   <= f_new;
              res_status <= ST_OK;
              res_pages  <= len_rd;
              res_free   <= f_new;
              state      <= S_MRD;
            end
          end
          S_MRD: state <= S_MWR;
          S_MWR: begin
            if (w == hi[PAGE_W-1:BIT_W]) begin
              state <= S_HRD;
            end else begin
              w     <= w + WORD_AW'(1);
              state <= S_MRD;
            end
          end
          S_HRD: state <= S_HWR;
          S_HWR: state <= S_RES;
          S_RES: begin
            if (res_load) begin
              m_tuser  <= res_status;
              m_tdata  <= {res_free, res_pad, res_pages, res_start};
              state    <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

[src/bitmap_page_allocator_core.sv]
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: request_bytes, block_start; tuser: op
// m_*       out  m_tvalid/m_tready    tdata: start, pages, padding, free; tuser: status
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Allocate: a bitmap walk over the pool (one page a cycle, one used-map word fetch per
//   32 pages), then a read and a write of each used-map word marked.
// Free: a check of the block head, then a read and a write of each used-map word cleared.
// Reset and every pool_pages write start a clearing pass over the used and
//   head maps; no item is taken meanwhile.
// A two-entry command queue sits between the classifier and the walker; the result
//   register holds one item, so the walker stalls only when that is still full.
module bitmap_page_allocator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [39:0]                        s_tdata,   // request_bytes[25:0], block_start[35:26]
  input  logic                               s_tuser,   // op
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [47:0]                        m_tdata,   // start_page, pages_taken, tail_padding, free_pages
  output logic [2:0]                         m_tuser,   // status
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bpa_pkg::*;

  logic [3:0]       page_code;
  logic [3:0]       extra;
  logic [3:0]       guard;
  logic [1:0]       fit;
  logic             allow_empty;
  logic [CNT_W-1:0] pool_raw;
  logic             cfg_wr;
  logic             pool_wr;
  cfg_t             cfg;
  logic             q_full, q_empty, push, pop;
  cmd_t             push_cmd, q_cmd;
  back_stat_t       stat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign pool_wr   = cfg_wr && cfg_index == CFG_POOL;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_code   <= '0;
      extra       <= '0;
      guard       <= '0;
      fit         <= '0;
      allow_empty <= 1'b0;
      pool_raw    <= CNT_W'(MAX_PAGES);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_PAGE_SIZE: page_code   <= cfg_data[3:0];
        CFG_EXTRA:     extra       <= cfg_data[3:0];
        CFG_GUARD:     guard       <= cfg_data[3:0];
        CFG_FIT:       fit         <= cfg_data[1:0];
        CFG_EMPTY_OK:  allow_empty <= cfg_data[0];
        CFG_POOL:      pool_raw    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pool size saturates at the map size
  always_comb begin
    cfg.page_code   = page_code;
    cfg.extra       = extra;
    cfg.guard       = guard;
    cfg.fit         = fit;
    cfg.allow_empty = allow_empty;
    cfg.pool        = (pool_raw > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pool_raw;
  end

  bpa_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg(cfg), .q_full(q_full), .clearing(stat.clearing),
    .push(push), .push_cmd(push_cmd));

  bpa_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd),
    .pop(pop), .pop_cmd(q_cmd), .full(q_full), .empty(q_empty));

  bpa_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .pool_wr(pool_wr),
    .q_empty(q_empty), .q_cmd(q_cmd), .pop(pop), .stat(stat),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !s_tready) else $error("item taken during map clear");

  a_free_within_pool: assert property (@(posedge clk) disable iff (rst)
    !stat.clearing |-> stat.free_cnt <= cfg.pool) else $error("free count above pool");

  a_failed_alloc_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_NOROOM || m_tuser == ST_NOFIT)
    |-> m_tdata[36:10] == '0) else $error("failed request carries a block");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ST_BADFREE) else $error("status code out of range");

endmodule
